FILE: design/ppc_pkg.sv
// Shared constants for the pulsed pump controller: widths, register indexes and reset values.
package ppc_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 4;
    localparam int PCT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [PCT_W-1:0]      t_pct;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx REG_PULSE_ON_TIME  = 3'd0;
    localparam t_cfg_idx REG_PULSE_OFF_TIME = 3'd1;
    localparam t_cfg_idx REG_COOLDOWN_TIME  = 3'd2;
    localparam t_cfg_idx REG_MAX_PULSES     = 3'd3;
    localparam t_cfg_idx REG_DRY_THRESHOLD  = 3'd4;
    localparam t_cfg_idx REG_WET_THRESHOLD  = 3'd5;

    localparam t_time  RST_PULSE_ON_TIME  = 32'd5000;
    localparam t_time  RST_PULSE_OFF_TIME = 32'd30000;
    localparam t_time  RST_COOLDOWN_TIME  = 32'd600000;
    localparam t_count RST_MAX_PULSES     = 4'd3;
    localparam t_pct   RST_DRY_THRESHOLD  = 7'd35;
    localparam t_pct   RST_WET_THRESHOLD  = 7'd60;

endpackage

FILE: design/pulsed_pump_controller.sv
// Top level of the pulsed pump controller: input register, tick logic and result register.
// Throughput: one transaction per cycle while the output is not stalled.
// The pump state feeds back through one register stage.
// The input stage stalls only while both stages are full and the output is stalled.
// Reset (synchronous, active low) empties both stages, clears the pump state and
// restores every configuration register to its default value.
module pulsed_pump_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  ppc_pkg::t_cfg_idx i_cfg_index,
    input  ppc_pkg::t_cfg_data i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ppc_pkg::t_time    i_now_ms,
    input  ppc_pkg::t_pct     i_soil_percent,
    input  logic              i_water_ok,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_pump_on,
    output logic              o_pulse_started,
    output logic              o_cooling_down,
    output ppc_pkg::t_count   o_pulses_done
);
    import ppc_pkg::*;

    t_time  r_pulse_on_time;
    t_time  r_pulse_off_time;
    t_time  r_cooldown_time;
    t_count r_max_pulses;
    t_pct   r_dry_threshold;
    t_pct   r_wet_threshold;

    logic   r_in_valid;
    t_time  r_now_ms;
    t_pct   r_soil_percent;
    logic   r_water_ok;

    logic   r_in_cooldown,   n_in_cooldown;
    t_time  r_cooldown_start, n_cooldown_start;
    logic   r_pumping,       n_pumping;
    t_time  r_pump_start,    n_pump_start;
    t_time  r_last_pulse_end, n_last_pulse_end;
    t_count r_pulse_count,   n_pulse_count;
    logic   n_started;

    logic   r_out_valid;
    logic   r_pump_on;
    logic   r_pulse_started;
    logic   r_cooling_down;
    t_count r_pulses_done;

    logic   advance;
    logic   cool_expired;
    logic   on_expired;
    logic   off_waiting;
    t_count count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_on_time  <= RST_PULSE_ON_TIME;
            r_pulse_off_time <= RST_PULSE_OFF_TIME;
            r_cooldown_time  <= RST_COOLDOWN_TIME;
            r_max_pulses     <= RST_MAX_PULSES;
            r_dry_threshold  <= RST_DRY_THRESHOLD;
            r_wet_threshold  <= RST_WET_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PULSE_ON_TIME:  r_pulse_on_time  <= i_cfg_data;
                REG_PULSE_OFF_TIME: r_pulse_off_time <= i_cfg_data;
                REG_COOLDOWN_TIME:  r_cooldown_time  <= i_cfg_data;
                REG_MAX_PULSES:     r_max_pulses     <= i_cfg_data[COUNT_W-1:0];
                REG_DRY_THRESHOLD:  r_dry_threshold  <= i_cfg_data[PCT_W-1:0];
                REG_WET_THRESHOLD:  r_wet_threshold  <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // The tick stage moves on when the result register is empty or being drained.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_now_ms       <= i_now_ms;
            r_soil_percent <= i_soil_percent;
            r_water_ok     <= i_water_ok;
        end
    end

    assign cool_expired = (r_now_ms - r_cooldown_start) >= r_cooldown_time;
    assign on_expired   = (r_now_ms - r_pump_start) >= r_pulse_on_time;
    assign off_waiting  = (r_now_ms - r_last_pulse_end) < r_pulse_off_time;

    always_comb begin
        n_in_cooldown    = r_in_cooldown;
        n_cooldown_start = r_cooldown_start;
        n_pumping        = r_pumping;
        n_pump_start     = r_pump_start;
        n_last_pulse_end = r_last_pulse_end;
        n_pulse_count    = r_pulse_count;
        n_started        = 1'b0;
        count_inc        = r_pulse_count + 1'b1;

        // An expired cooldown clears the session count before the rest of the tick.
        if (r_in_cooldown && cool_expired) begin
            n_in_cooldown = 1'b0;
            n_pulse_count = '0;
        end

        if (!n_in_cooldown) begin
            if (r_pumping) begin
                if (on_expired) begin
                    n_pumping        = 1'b0;
                    n_last_pulse_end = r_now_ms;
                    n_pulse_count    = count_inc;
                    if (count_inc >= r_max_pulses) begin
                        n_in_cooldown    = 1'b1;
                        n_cooldown_start = r_now_ms;
                    end
                end
            end else if (n_pulse_count != '0 && off_waiting) begin
                n_pulse_count = n_pulse_count;
            end else if (n_pulse_count != '0 && r_soil_percent >= r_wet_threshold) begin
                n_in_cooldown    = 1'b1;
                n_cooldown_start = r_now_ms;
                n_pulse_count    = '0;
            end else if (r_water_ok && r_soil_percent < r_dry_threshold) begin
                n_pumping    = 1'b1;
                n_pump_start = r_now_ms;
                n_started    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cooldown    <= 1'b0;
            r_cooldown_start <= '0;
            r_pumping        <= 1'b0;
            r_pump_start     <= '0;
            r_last_pulse_end <= '0;
            r_pulse_count    <= '0;
        end else if (r_in_valid && advance) begin
            r_in_cooldown    <= n_in_cooldown;
            r_cooldown_start <= n_cooldown_start;
            r_pumping        <= n_pumping;
            r_pump_start     <= n_pump_start;
            r_last_pulse_end <= n_last_pulse_end;
            r_pulse_count    <= n_pulse_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_pump_on       <= n_pumping;
            r_pulse_started <= n_started;
            r_cooling_down  <= n_in_cooldown;
            r_pulses_done   <= n_pulse_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pump_on       = r_pump_on;
    assign o_pulse_started = r_pulse_started;
    assign o_cooling_down  = r_cooling_down;
    assign o_pulses_done   = r_pulses_done;

`ifndef SYNTHESIS
    // The pump never runs during a cooldown lockout.
    a_no_pump_in_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pumping && r_in_cooldown))
        else $error("pump running during cooldown");

    // A pulse that starts leaves the pump driven in the same result.
    a_start_drives_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pulse_started) |-> (o_pump_on && !o_cooling_down))
        else $error("pulse start without pump drive");

    // A new result only appears when a transaction sat in the input register.
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result without a transaction");

    // State changes only when a transaction moves into the result register.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(r_in_valid && advance) |-> $stable(r_pulse_count)
            && $stable(r_pumping) && $stable(r_in_cooldown))
        else $error("state changed without a transaction");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the pulsed pump controller with its own tick predictor.
`timescale 1ns / 1ps

module testbench;
    import ppc_pkg::*;

    typedef struct packed {
        logic   pump_on;
        logic   pulse_started;
        logic   cooling_down;
        t_count pulses_done;
    } t_pump_status;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_index = REG_PULSE_ON_TIME;
    t_cfg_data i_cfg_data = '0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_time     i_now_ms = '0;
    t_pct      i_soil_percent = '0;
    logic      i_water_ok = 1'b0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    logic      o_pump_on;
    logic      o_pulse_started;
    logic      o_cooling_down;
    t_count    o_pulses_done;

    pulsed_pump_controller dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_now_ms(i_now_ms),
        .i_soil_percent(i_soil_percent),
        .i_water_ok(i_water_ok),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_pump_on(o_pump_on),
        .o_pulse_started(o_pulse_started),
        .o_cooling_down(o_cooling_down),
        .o_pulses_done(o_pulses_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_time  on_time_ms   = RST_PULSE_ON_TIME;
    t_time  off_time_ms  = RST_PULSE_OFF_TIME;
    t_time  lockout_ms   = RST_COOLDOWN_TIME;
    t_count pulse_limit  = RST_MAX_PULSES;
    t_pct   dry_level    = RST_DRY_THRESHOLD;
    t_pct   wet_level    = RST_WET_THRESHOLD;

    logic   lockout_active = 1'b0;
    t_time  lockout_stamp  = '0;
    logic   pump_running   = 1'b0;
    t_time  pump_stamp     = '0;
    t_time  pulse_end_stamp = '0;
    t_count session_pulses = '0;

    t_pump_status expected_status[$];
    t_pump_status oldest_status;
    logic   prev_cooling = 1'b0;

    int sender_gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int ticks_checked = 0;
    int pulse_starts = 0;
    int cooldown_entries = 0;
    int settings_used = 0;

    t_time clock_ms = '0;
    int    soil_level = 50;

    function automatic t_pump_status predict_tick(input t_time now, input t_pct soil,
                                                  input logic water);
        t_pump_status status;
        logic  started;
        logic  proceed;
        t_time elapsed;
        started = 1'b0;
        proceed = 1'b1;
        if (lockout_active) begin
            elapsed = now - lockout_stamp;
            if (elapsed >= lockout_ms) begin
                lockout_active = 1'b0;
                session_pulses = '0;
            end else begin
                proceed = 1'b0;
            end
        end
        if (proceed) begin
            if (pump_running) begin
                elapsed = now - pump_stamp;
                if (elapsed >= on_time_ms) begin
                    pump_running = 1'b0;
                    pulse_end_stamp = now;
                    session_pulses = session_pulses + 4'd1;
                    if (session_pulses >= pulse_limit) begin
                        lockout_active = 1'b1;
                        lockout_stamp = now;
                    end
                end
            end else if (session_pulses != 0 && t_time'(now - pulse_end_stamp) < off_time_ms) begin
                proceed = 1'b0;
            end else if (session_pulses != 0 && soil >= wet_level) begin
                lockout_active = 1'b1;
                lockout_stamp = now;
                session_pulses = '0;
            end else if (water && soil < dry_level) begin
                pump_running = 1'b1;
                pump_stamp = now;
                started = 1'b1;
            end
        end
        status.pump_on = pump_running;
        status.pulse_started = started;
        status.cooling_down = lockout_active;
        status.pulses_done = session_pulses;
        return status;
    endfunction

    task automatic send_tick(input t_time now, input t_pct soil, input logic water);
        while ($urandom_range(1, 100) <= sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms <= now;
        i_soil_percent <= soil;
        i_water_ok <= water;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_status.push_back(predict_tick(now, soil, water));
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_time on_ms, input t_time off_ms, input t_time lock_ms,
                                 input t_count limit, input t_pct dry, input t_pct wet);
        t_cfg_data values[6];
        t_cfg_idx  idx;
        values[REG_PULSE_ON_TIME]  = on_ms;
        values[REG_PULSE_OFF_TIME] = off_ms;
        values[REG_COOLDOWN_TIME]  = lock_ms;
        values[REG_MAX_PULSES]     = t_cfg_data'(limit);
        values[REG_DRY_THRESHOLD]  = t_cfg_data'(dry);
        values[REG_WET_THRESHOLD]  = t_cfg_data'(wet);
        for (int i = 0; i < 6; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= values[i];
            @(posedge i_clk);
            case (idx)
                REG_PULSE_ON_TIME:  on_time_ms = values[i];
                REG_PULSE_OFF_TIME: off_time_ms = values[i];
                REG_COOLDOWN_TIME:  lockout_ms = values[i];
                REG_MAX_PULSES:     pulse_limit = values[i][COUNT_W-1:0];
                REG_DRY_THRESHOLD:  dry_level = values[i][PCT_W-1:0];
                REG_WET_THRESHOLD:  wet_level = values[i][PCT_W-1:0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status.size() == 0) begin
                mismatches++;
                $display("%0t: result with no transaction pending, actual %b%b%b%0d", $time,
                         o_pump_on, o_pulse_started, o_cooling_down, o_pulses_done);
            end else begin
                oldest_status = expected_status.pop_front();
                check_field("pump_on", 32'(oldest_status.pump_on), 32'(o_pump_on));
                check_field("pulse_started", 32'(oldest_status.pulse_started),
                            32'(o_pulse_started));
                check_field("cooling_down", 32'(oldest_status.cooling_down),
                            32'(o_cooling_down));
                check_field("pulses_done", 32'(oldest_status.pulses_done),
                            32'(o_pulses_done));
                ticks_checked++;
                if (oldest_status.pulse_started) pulse_starts++;
                if (oldest_status.cooling_down && !prev_cooling) cooldown_entries++;
                prev_cooling = oldest_status.cooling_down;
            end
        end
        i_out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end

    task automatic test_default_session();
        send_tick(32'd0, 7'd20, 1'b1);
        send_tick(32'd4999, 7'd20, 1'b1);
        send_tick(32'd5000, 7'd20, 1'b1);
        send_tick(32'd20000, 7'd20, 1'b1);
        send_tick(32'd35000, 7'd20, 1'b1);
        send_tick(32'd40000, 7'd20, 1'b1);
        send_tick(32'd70000, 7'd70, 1'b1);
        send_tick(32'd100000, 7'd10, 1'b1);
        send_tick(32'd700000, 7'd20, 1'b0);
        wait_idle();
    endtask

    task automatic test_limits();
        apply_setting(32'd0, 32'd0, 32'd0, 4'd0, 7'd127, 7'd127);
        send_tick(32'hFFFF_FFFF, 7'd126, 1'b1);
        send_tick(32'hFFFF_FFFF, 7'd127, 1'b1);
        send_tick(32'd0, 7'd0, 1'b1);
        wait_idle();
        apply_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 7'd0, 7'd0);
        send_tick(32'hFFFF_FFFE, 7'd0, 1'b1);
        send_tick(32'hFFFF_FFFF, 7'd0, 1'b1);
        send_tick(32'd0, 7'd0, 1'b1);
        send_tick(32'hFFFF_FFFE, 7'd0, 1'b1);
        send_tick(32'd5, 7'd0, 1'b0);
        wait_idle();
    endtask

    function automatic t_time pick_duration(input int typical);
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return t_time'($urandom_range(0, typical));
        endcase
    endfunction

    function automatic t_pct pick_threshold(input int lo, input int hi);
        if ($urandom_range(0, 9) == 0) return t_pct'($urandom_range(0, 127));
        return t_pct'($urandom_range(lo, hi));
    endfunction

    task automatic send_random_tick();
        int   roll;
        logic water;
        roll = $urandom_range(0, 49);
        if (roll == 0) clock_ms = $urandom;
        else if (roll == 1) clock_ms = clock_ms - t_time'($urandom_range(1, 16));
        else clock_ms = clock_ms + t_time'($urandom_range(0, 12));
        if ($urandom_range(0, 19) == 0) soil_level = $urandom_range(0, 127);
        else soil_level = soil_level + $urandom_range(0, 8) - 4;
        if (soil_level < 0) soil_level = 0;
        if (soil_level > 127) soil_level = 127;
        water = ($urandom_range(0, 9) != 0);
        send_tick(clock_ms, t_pct'(soil_level), water);
    endtask

    task automatic test_random();
        t_count limit;
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin sender_gap_pct = 0;  stall_pct = 0;  end
                1: begin sender_gap_pct = 65; stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  stall_pct = 65; end
                default: begin sender_gap_pct = 22; stall_pct = 22; end
            endcase
            limit = ($urandom_range(0, 7) == 0) ? t_count'($urandom_range(0, 15))
                                                : t_count'($urandom_range(1, 4));
            apply_setting(pick_duration(20), pick_duration(40), pick_duration(120), limit,
                          pick_threshold(30, 60), pick_threshold(45, 80));
            soil_level = $urandom_range(20, 80);
            repeat (150) send_random_tick();
            wait_idle();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_session();
        test_limits();
        test_random();
        repeat (5) @(posedge i_clk);
        $display("Checked %0d ticks under %0d register settings and four idle patterns.",
                 ticks_checked, settings_used);
        $display("Saw %0d pulse starts and %0d cooldown entries.", pulse_starts,
                 cooldown_entries);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d transactions outstanding.", expected_status.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule
